// ----- rtl/core/hmq_pkg.sv -----
package hmq_pkg;

  // Result status codes, carried on m_tuser
  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_EXTRACTED = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Operation codes, carried on s_tuser
  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

endpackage

// ----- rtl/core/hmq_ram.sv -----
// Heap entry store: one write port, two read ports, registered read data.
module hmq_ram #(
  parameter int DEPTH = 512,
  parameter int DW    = 42,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/core/hmq_engine.sv -----
// Sift sequencer. Uses the hole method: the moving entry stays in a register
// and each level writes back one entry: a displaced one, or finally itself.
module hmq_engine import hmq_pkg::*; #(
  parameter int CAPACITY = 512,
  parameter int KEY_BITS = 30,
  parameter int TAG_BITS = 12,
  localparam int AW      = $clog2(CAPACITY),
  localparam int CW      = $clog2(CAPACITY + 1),
  localparam int EW      = KEY_BITS + TAG_BITS
) (
  input  logic                clk,
  input  logic                rst,
  // item in
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [KEY_BITS-1:0] in_key,
  input  logic [TAG_BITS-1:0] in_tag,
  // result out
  output logic                res_valid,
  input  logic                res_ready,
  output status_t             res_status,
  output logic [KEY_BITS-1:0] res_key,
  output logic [TAG_BITS-1:0] res_tag,
  output logic [CW-1:0]       res_count,
  // entry store
  output logic                ram_we,
  output logic [AW-1:0]       ram_waddr,
  output logic [EW-1:0]       ram_wdata,
  output logic [AW-1:0]       ram_raddr_a,
  output logic [AW-1:0]       ram_raddr_b,
  input  logic [EW-1:0]       ram_rdata_a,
  input  logic [EW-1:0]       ram_rdata_b
);

  localparam int LW = AW + 2;

  typedef enum logic [2:0] {
    IDLE, UP_RD, UP_CMP, EX_RD, EX_LOAD, DN_RD, DN_CMP, DONE
  } state_t;

  state_t              state;
  logic [CW-1:0]       count;
  logic [AW-1:0]       pos;
  logic [KEY_BITS-1:0] mov_key;
  logic [TAG_BITS-1:0] mov_tag;

  logic [AW-1:0]       parent;
  logic [LW-1:0]       left_w;
  logic [LW-1:0]       right_w;
  logic [LW-1:0]       count_w;
  logic                left_ok;
  logic                right_ok;
  logic [KEY_BITS-1:0] a_key;
  logic [KEY_BITS-1:0] b_key;
  logic                pick_right;
  logic [EW-1:0]       child_data;
  logic [KEY_BITS-1:0] child_key;
  logic [AW-1:0]       child_addr;
  logic                up_less;
  logic                dn_move;

  assign parent     = (pos - AW'(1)) >> 1;
  assign left_w     = {1'b0, pos, 1'b1};
  assign right_w    = left_w + LW'(1);
  assign count_w    = LW'(count);
  assign left_ok    = left_w < count_w;
  assign right_ok   = right_w < count_w;
  assign a_key      = ram_rdata_a[KEY_BITS-1:0];
  assign b_key      = ram_rdata_b[KEY_BITS-1:0];
  // smaller child, left on a tie
  assign pick_right = right_ok && (b_key < a_key);
  assign child_data = pick_right ? ram_rdata_b : ram_rdata_a;
  assign child_key  = child_data[KEY_BITS-1:0];
  assign child_addr = pick_right ? right_w[AW-1:0] : left_w[AW-1:0];
  assign up_less    = mov_key < a_key;
  assign dn_move    = child_key < mov_key;

  assign in_ready  = (state == IDLE);
  assign res_valid = (state == DONE);

  // store access
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = pos;
    ram_wdata   = {mov_tag, mov_key};
    ram_raddr_a = '0;
    ram_raddr_b = '0;
    unique case (state)
      UP_RD: begin
        ram_raddr_a = parent;
        ram_we      = (pos == '0);
      end
      UP_CMP: begin
        ram_we = 1'b1;
        if (up_less) begin
          ram_wdata = ram_rdata_a;
        end
      end
      EX_RD: begin
        ram_raddr_b = count[AW-1:0];
      end
      DN_RD: begin
        ram_raddr_a = left_w[AW-1:0];
        ram_raddr_b = right_w[AW-1:0];
        ram_we      = !left_ok;
      end
      DN_CMP: begin
        ram_we = 1'b1;
        if (dn_move) begin
          ram_wdata = child_data;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            res_key <= '0;
            res_tag <= '0;
            if (in_cmd == CMD_INSERT) begin
              if (count == CW'(CAPACITY)) begin
                res_status <= ST_FULL;
                res_count  <= count;
                state      <= DONE;
              end else begin
                mov_key    <= in_key;
                mov_tag    <= in_tag;
                pos        <= count[AW-1:0];
                count      <= count + CW'(1);
                res_status <= ST_INSERTED;
                res_count  <= count + CW'(1);
                state      <= UP_RD;
              end
            end else begin
              if (count == '0) begin
                res_status <= ST_EMPTY;
                res_count  <= '0;
                state      <= DONE;
              end else begin
                count      <= count - CW'(1);
                res_status <= ST_EXTRACTED;
                res_count  <= count - CW'(1);
                state      <= EX_RD;
              end
            end
          end
        end
        UP_RD: begin
          state <= (pos == '0) ? DONE : UP_CMP;
        end
        UP_CMP: begin
          if (up_less) begin
            pos   <= parent;
            state <= UP_RD;
          end else begin
            state <= DONE;
          end
        end
        EX_RD: begin
          state <= EX_LOAD;
        end
        EX_LOAD: begin
          res_key <= a_key;
          res_tag <= ram_rdata_a[EW-1:KEY_BITS];
          mov_key <= b_key;
          mov_tag <= ram_rdata_b[EW-1:KEY_BITS];
          pos     <= '0;
          state   <= (count == '0) ? DONE : DN_RD;
        end
        DN_RD: begin
          state <= left_ok ? DN_CMP : DONE;
        end
        DN_CMP: begin
          if (dn_move) begin
            pos   <= child_addr;
            state <= DN_RD;
          end else begin
            state <= DONE;
          end
        end
        DONE: begin
          if (res_ready) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/binary_min_heap_queue_top.sv -----
// Binary min-heap priority queue of (key, tag) entries.
// Input channel s_*: one beat is one command. s_tuser = cmd (0 insert,
//   1 extract min); s_tdata = key, tag. An insert into a full heap is dropped.
// Output channel m_*: exactly one result beat per command. m_tuser = status
//   (inserted, extracted, empty, full); m_tdata = out_key, out_tag, count.
//   out_key/out_tag are zero except on a successful extract.
// Equal keys: an inserted entry stops below an equal parent; a sinking entry
//   stays above equal children, and the left child wins a tie between them.
// Sequencing: the heap sits in one memory (two read ports, one write port).
//   Each level is a read state, then a compare and write-back state; at
//   the root or a leaf end only the read state runs. An extract first
//   reads the root and the last entry (EX_RD, EX_LOAD) before sinking;
//   full/empty answer straight from idle.
// Throughput: one command in flight; s_tready is high only while the
//   sequencer is idle. A result register decouples m_*: the next command is
//   taken while the previous result still waits for m_tready.
// Stall: if m_tready stays low, the finished result waits in the sequencer
//   and no further command is taken.
// Reset (rst, synchronous): the heap is empty and m_tvalid drops. The entry
//   memory is not cleared; only entries below the count are ever used.
module binary_min_heap_queue_top import hmq_pkg::*; #(
  parameter int CAPACITY = 512,
  parameter int KEY_BITS = 30,
  parameter int TAG_BITS = 12,
  localparam int AW      = $clog2(CAPACITY),
  localparam int CW      = $clog2(CAPACITY + 1),
  localparam int EW      = KEY_BITS + TAG_BITS,
  localparam int SDW     = ((EW + 7) / 8) * 8,
  localparam int MDW     = ((EW + CW + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [SDW-1:0] s_tdata,   // key, tag, zero pad
  input  logic [0:0]     s_tuser,   // cmd
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [MDW-1:0] m_tdata,   // out_key, out_tag, count, zero pad
  output logic [1:0]     m_tuser    // status
);

  logic                res_valid;
  logic                res_ready;
  status_t             res_status;
  logic [KEY_BITS-1:0] res_key;
  logic [TAG_BITS-1:0] res_tag;
  logic [CW-1:0]       res_count;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [EW-1:0]       ram_wdata;
  logic [AW-1:0]       ram_raddr_a;
  logic [AW-1:0]       ram_raddr_b;
  logic [EW-1:0]       ram_rdata_a;
  logic [EW-1:0]       ram_rdata_b;

  hmq_engine #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_cmd      (s_tuser[0]),
    .in_key      (s_tdata[KEY_BITS-1:0]),
    .in_tag      (s_tdata[EW-1:KEY_BITS]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_status  (res_status),
    .res_key     (res_key),
    .res_tag     (res_tag),
    .res_count   (res_count),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr_a (ram_raddr_a),
    .ram_raddr_b (ram_raddr_b),
    .ram_rdata_a (ram_rdata_a),
    .ram_rdata_b (ram_rdata_b)
  );

  hmq_ram #(
    .DEPTH (CAPACITY),
    .DW    (EW)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  // result register: loads when empty or being drained this cycle
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tuser <= res_status;
      m_tdata <= MDW'({res_count, res_tag, res_key});
    end
  end

endmodule

// ----- rtl/core/hmq_checker.sv -----
module hmq_checker import hmq_pkg::*; #(
  parameter int CAPACITY = 512,
  parameter int KEY_BITS = 30,
  parameter int TAG_BITS = 12,
  localparam int CW      = $clog2(CAPACITY + 1),
  localparam int EW      = KEY_BITS + TAG_BITS,
  localparam int SDW     = ((EW + 7) / 8) * 8,
  localparam int MDW     = ((EW + CW + 7) / 8) * 8
) (
  input logic           clk,
  input logic           rst,
  input logic           s_tvalid,
  input logic           s_tready,
  input logic [SDW-1:0] s_tdata,
  input logic [0:0]     s_tuser,
  input logic           m_tvalid,
  input logic           m_tready,
  input logic [MDW-1:0] m_tdata,
  input logic [1:0]     m_tuser
);

  logic [KEY_BITS-1:0] out_key;
  logic [TAG_BITS-1:0] out_tag;
  logic [CW-1:0]       out_count;

  assign out_key   = m_tdata[KEY_BITS-1:0];
  assign out_tag   = m_tdata[EW-1:KEY_BITS];
  assign out_count = m_tdata[EW+CW-1:EW];

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // one command in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("command taken while another is in flight");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_FULL |-> out_count == CW'(CAPACITY))
    else $error("full status with count below capacity");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_EMPTY |-> out_count == '0)
    else $error("empty status with nonzero count");

  a_no_entry: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_INSERTED || m_tuser == ST_EMPTY || m_tuser == ST_FULL)
    |-> out_key == '0 && out_tag == '0)
    else $error("entry fields nonzero without an extract");

endmodule

bind binary_min_heap_queue_top hmq_checker #(
  .CAPACITY (CAPACITY),
  .KEY_BITS (KEY_BITS),
  .TAG_BITS (TAG_BITS)
) u_hmq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import hmq_pkg::*;

  localparam int CAP      = 512;
  localparam int KEY_W    = 30;
  localparam int TAG_W    = 12;
  localparam int CNT_W    = 10;
  localparam int SDW      = 48;
  localparam int MDW      = 56;
  localparam int TAG_LSB  = KEY_W;
  localparam int CNT_LSB  = KEY_W + TAG_W;
  localparam int SETTLE   = 40;       // above the worst command latency
  localparam int LIMIT    = 500000;   // cycles, several times the slowest run
  localparam logic [KEY_W-1:0] KEY_MAX = '1;
  localparam logic [TAG_W-1:0] TAG_MAX = '1;

  typedef struct packed {
    status_t            status;
    logic [KEY_W-1:0]   key;
    logic [TAG_W-1:0]   tag;
    logic [CNT_W-1:0]   count;
  } heap_res_t;

  // One directed command; res is used only when it is typed in by hand
  typedef struct {
    logic             cmd;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    bit               typed;
    heap_res_t        res;
  } heap_cmd_row_t;

  logic           clk;
  logic           rst;
  logic           s_tvalid;
  logic           s_tready;
  logic [SDW-1:0] s_tdata;   // key, tag, zero pad
  logic [0:0]     s_tuser;   // cmd
  logic           m_tvalid;
  logic           m_tready;
  logic [MDW-1:0] m_tdata;   // out_key, out_tag, count, zero pad
  logic [1:0]     m_tuser;   // status

  binary_min_heap_queue_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Shadow heap, same layout as the block: children of i at 2i+1, 2i+2
  logic [KEY_W-1:0] heap_keys [CAP];
  logic [TAG_W-1:0] heap_tags [CAP];
  int               heap_count;

  heap_res_t     pending_results [$];
  heap_cmd_row_t directed_rows [$];
  int            errors;
  int            cycles;
  bit            no_gaps;

  // clock: 8 ns period
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void swap_slots(int a, int b);
    logic [KEY_W-1:0] k;
    logic [TAG_W-1:0] t;
    k = heap_keys[a];
    t = heap_tags[a];
    heap_keys[a] = heap_keys[b];
    heap_tags[a] = heap_tags[b];
    heap_keys[b] = k;
    heap_tags[b] = t;
  endfunction

  // Applies one command to the shadow heap and returns the result beat
  function automatic heap_res_t heap_apply(logic cmd, logic [KEY_W-1:0] key,
                                           logic [TAG_W-1:0] tag);
    heap_res_t r;
    int pos;
    int par;
    int lft;
    int best;
    bit done;
    r = '0;
    if (cmd == CMD_INSERT) begin
      if (heap_count >= CAP) begin
        r.status = ST_FULL;            // dropped, nothing changes
      end else begin
        pos = heap_count;
        heap_keys[pos] = key;
        heap_tags[pos] = tag;
        heap_count++;
        done = 0;
        // sift up only while strictly smaller than the parent
        while (pos > 0 && !done) begin
          par = (pos - 1) / 2;
          if (heap_keys[pos] < heap_keys[par]) begin
            swap_slots(pos, par);
            pos = par;
          end else begin
            done = 1;
          end
        end
        r.status = ST_INSERTED;
      end
    end else if (heap_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.key = heap_keys[0];
      r.tag = heap_tags[0];
      heap_count--;
      heap_keys[0] = heap_keys[heap_count];
      heap_tags[0] = heap_tags[heap_count];
      pos  = 0;
      done = 0;
      // sift down: strictly smaller child wins, left wins a tie
      while (!done) begin
        lft  = 2 * pos + 1;
        best = pos;
        if (lft < heap_count && heap_keys[lft] < heap_keys[best])
          best = lft;
        if (lft + 1 < heap_count && heap_keys[lft + 1] < heap_keys[best])
          best = lft + 1;
        if (best == pos) begin
          done = 1;
        end else begin
          swap_slots(pos, best);
          pos = best;
        end
      end
      r.status = ST_EXTRACTED;
    end
    r.count = CNT_W'(heap_count);
    return r;
  endfunction

  function automatic void add_row(logic cmd, logic [KEY_W-1:0] key,
                                  logic [TAG_W-1:0] tag, bit typed,
                                  status_t st, logic [KEY_W-1:0] okey,
                                  logic [TAG_W-1:0] otag, int cnt);
    heap_cmd_row_t row;
    row.cmd          = cmd;
    row.key          = key;
    row.tag          = tag;
    row.typed        = typed;
    row.res.status   = st;
    row.res.key      = okey;
    row.res.tag      = otag;
    row.res.count    = CNT_W'(cnt);
    directed_rows.push_back(row);
  endfunction

  // Mix of tight ranges (lots of equal keys), extremes and full range
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(3))
      0: k = KEY_W'($urandom_range(15));
      1: k = $urandom_range(1) ? KEY_MAX : '0;
      default: k = KEY_W'($urandom);
    endcase
    return k;
  endfunction

  // Drives one command beat and books its result once it is taken.
  // Called just after the clock rises; returns once the beat has been accepted.
  task automatic send_cmd(logic cmd, logic [KEY_W-1:0] key,
                          logic [TAG_W-1:0] tag, bit typed, heap_res_t typed_res);
    heap_res_t r;
    while (!no_gaps && $urandom_range(99) < 6) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {{(SDW - KEY_W - TAG_W){1'b0}}, tag, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = heap_apply(cmd, key, tag);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic send_random(int insert_pct);
    send_cmd(($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_EXTRACT,
             pick_key(), TAG_W'($urandom_range(4095)), 1'b0, '0);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result side: random backpressure, none during the quiet stretch
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else     m_tready <= no_gaps || ($urandom_range(99) >= 6);
  end

  // Result checker, in order against the predictor
  always @(posedge clk) begin
    heap_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d tdata %h",
               m_tuser, m_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser);
          errors++;
        end
        if (m_tdata[KEY_W-1:0] !== want.key) begin
          $error("out_key: expected %h, got %h", want.key, m_tdata[KEY_W-1:0]);
          errors++;
        end
        if (m_tdata[TAG_LSB +: TAG_W] !== want.tag) begin
          $error("out_tag: expected %h, got %h", want.tag,
                 m_tdata[TAG_LSB +: TAG_W]);
          errors++;
        end
        if (m_tdata[CNT_LSB +: CNT_W] !== want.count) begin
          $error("count: expected %0d, got %0d", want.count,
                 m_tdata[CNT_LSB +: CNT_W]);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = CMD_INSERT;
    m_tready   = 1'b0;
    heap_count = 0;
    errors     = 0;
    cycles     = 0;
    no_gaps    = 1'b0;

    // Directed table. Hand-typed results where obvious, predictor elsewhere.
    add_row(CMD_EXTRACT, '0, '0, 1, ST_EMPTY, '0, '0, 0);          // empty after reset
    add_row(CMD_INSERT, KEY_MAX, TAG_MAX, 1, ST_INSERTED, '0, '0, 1);
    add_row(CMD_EXTRACT, '0, '0, 1, ST_EXTRACTED, KEY_MAX, TAG_MAX, 0);
    add_row(CMD_EXTRACT, KEY_MAX, TAG_MAX, 1, ST_EMPTY, '0, '0, 0);
    add_row(CMD_INSERT, '0, '0, 1, ST_INSERTED, '0, '0, 1);
    // equal keys: siblings tie, inserts stop under an equal parent
    add_row(CMD_INSERT, 30'd5, 12'd1, 0, ST_INSERTED, '0, '0, 0);
    add_row(CMD_INSERT, 30'd5, 12'd2, 0, ST_INSERTED, '0, '0, 0);
    add_row(CMD_INSERT, 30'd5, 12'd3, 0, ST_INSERTED, '0, '0, 0);
    add_row(CMD_INSERT, 30'd3, 12'd4, 0, ST_INSERTED, '0, '0, 0);
    add_row(CMD_INSERT, 30'd5, 12'd5, 0, ST_INSERTED, '0, '0, 0);
    add_row(CMD_INSERT, KEY_MAX, 12'd6, 0, ST_INSERTED, '0, '0, 0);
    add_row(CMD_EXTRACT, '0, '0, 1, ST_EXTRACTED, '0, '0, 6);
    for (int i = 0; i < 6; i++)
      add_row(CMD_EXTRACT, '0, '0, 0, ST_EMPTY, '0, '0, 0);
    add_row(CMD_EXTRACT, '0, '0, 1, ST_EMPTY, '0, '0, 0);
    // alternating bit patterns on key and tag
    add_row(CMD_INSERT, 30'h2AAAAAAA, 12'h555, 0, ST_INSERTED, '0, '0, 0);
    add_row(CMD_INSERT, 30'h15555555, 12'hAAA, 0, ST_INSERTED, '0, '0, 0);
    add_row(CMD_EXTRACT, '0, '0, 0, ST_EMPTY, '0, '0, 0);
    add_row(CMD_EXTRACT, '0, '0, 0, ST_EMPTY, '0, '0, 0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_cmd(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].tag,
               directed_rows[i].typed, directed_rows[i].res);

    // Fill to capacity, mostly inserts; first part runs with no gaps at all
    no_gaps = 1'b1;
    while (heap_count < CAP) begin
      if (heap_count >= 200) no_gaps = 1'b0;
      send_random(90);
    end
    no_gaps = 1'b0;
    // inserts into a full heap, one slot freed and refilled between
    for (int i = 0; i < 8; i++)
      send_random(i == 4 ? 0 : 100);

    // let everything come back before draining
    wait_drained();

    // Drain to empty, mostly extracts, then a few on the empty heap
    while (heap_count > 0)
      send_random(10);
    for (int i = 0; i < 4; i++)
      send_random(0);

    // Mixed traffic around a shallow heap
    for (int i = 0; i < 60; i++)
      send_random(55);

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
